[design/nrm_pkg.sv]
// ----------------------------------------------------------------------------
// nrm_pkg
// Shared types and constants of the normal density / cumulative table block.
// ----------------------------------------------------------------------------
`default_nettype none

package nrm_pkg;

    // Fixed-point formats
    localparam int FRAC_BITS  = 16;
    localparam int STEP_FRAC  = 8;
    localparam int POS_FRAC   = FRAC_BITS + STEP_FRAC;
    localparam int FIELD_W    = 24;
    localparam int MAG_W      = 24;
    localparam int SIGMA_W    = 23;
    localparam int Q_W        = 22;
    localparam int HEAD_SHIFT = Q_W - FRAC_BITS;
    localparam int RANGE_W    = 22;
    localparam int STEP_W     = 24;
    localparam int POS_W      = Q_W + STEP_W;
    localparam int IDXF_W     = POS_W - POS_FRAC;
    localparam int ENTRY_W    = 17;
    localparam int LIDX_W     = 12;
    localparam int PROD_W     = (ENTRY_W + 1) + (POS_FRAC + 1);
    localparam int ACC_W      = PROD_W + 2;

    localparam logic [RANGE_W-1:0] RANGE_CAP     = RANGE_W'(39 << FRAC_BITS);
    localparam logic [ENTRY_W-1:0] PROB_ONE      = ENTRY_W'(1 << FRAC_BITS);
    localparam logic [RANGE_W-1:0] RANGE_RESET   = RANGE_W'(393216);
    localparam logic [STEP_W-1:0]  STEP_RESET    = STEP_W'(25600);

    // Item modes
    localparam logic [1:0] MODE_LOAD_PDF = 2'd0;
    localparam logic [1:0] MODE_LOAD_CDF = 2'd1;
    localparam logic [1:0] MODE_PDF      = 2'd2;
    localparam logic [1:0] MODE_CDF      = 2'd3;

    // Result status
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_SAT      = 2'd1;
    localparam logic [1:0] STAT_BAD_SIG  = 2'd2;
    localparam logic [1:0] STAT_LOAD_ACK = 2'd3;

    // Configuration register indexes
    localparam logic CFG_RANGE = 1'b0;
    localparam logic CFG_STEP  = 1'b1;

    // Control that travels with each item
    typedef struct packed {
        logic                valid;
        logic [1:0]          mode;
        logic                neg;
        logic                bad;
        logic                tail;
        logic [LIDX_W-1:0]   ld_idx;
        logic [ENTRY_W-1:0]  ld_val;
    } ctrl_t;

endpackage

`default_nettype wire

[design/normal_pdf_cdf_lut_interp.sv]
// ----------------------------------------------------------------------------
// normal_pdf_cdf_lut_interp
// Standard normal density / cumulative by linear interpolation in two tables.
// ----------------------------------------------------------------------------
// Usage:
//   Drive an item on mode and the payload ports and raise start; it is
//   taken at every rising edge with start high, since busy stays low.
//   Load modes write one table entry; query modes standardize
//   z = (x - mean) / sigma, interpolate the table and fold negative z.
//   Each item gives one result on result_value / status, marked by a
//   one-cycle result_valid strobe, after the input, divider and A to D stages.
//   One item enters per cycle: the 22-stage divider (one quotient bit
//   per stage) and the table RAMs are fully pipelined, and each table is
//   kept in two RAM copies so both interpolation points read at once.
//   Loads write the tables at the read stage, so results follow item order.
//   The receiver cannot stall; every result must be taken in its cycle.
//   Configuration: write range_limit (index 0) or inverse_step (index 1)
//   through cfg_we / cfg_index / cfg_data while no item is in flight.
//   Reset clears all valid bits and loads the register defaults; table
//   contents are undefined until loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module normal_pdf_cdf_lut_interp
    import nrm_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    output logic                     busy,
    input  wire logic [1:0]          mode,
    input  wire logic signed [23:0]  x_value,
    input  wire logic signed [23:0]  mean_value,
    input  wire logic signed [23:0]  sigma_value,
    input  wire logic [11:0]         entry_index,
    input  wire logic [16:0]         entry_value,
    output logic                     result_valid,
    output logic      [16:0]         result_value,
    output logic      [1:0]          status,
    input  wire logic                cfg_we,
    input  wire logic                cfg_index,
    input  wire logic [23:0]         cfg_data
);

    // Configuration registers
    logic [RANGE_W-1:0] range_reg;
    logic [STEP_W-1:0]  step_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            range_reg <= RANGE_RESET;
            step_reg  <= STEP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_RANGE: range_reg <= cfg_data[RANGE_W-1:0];
                CFG_STEP:  step_reg  <= cfg_data;
                default:   range_reg <= range_reg;
            endcase
        end
    end

    // Every cycle takes a new item
    assign busy = 1'b0;

    // Input stage: difference, magnitude, sign and early checks
    logic signed [FIELD_W:0] diff;
    logic [FIELD_W:0]        diff_abs;
    logic [MAG_W-1:0]        mag;
    logic                    bad;
    logic                    over;
    ctrl_t                   in_next;
    ctrl_t                   in_reg;
    logic [MAG_W-1:0]        mag_reg;
    logic [SIGMA_W-1:0]      sigma_reg;

    assign diff     = $signed({x_value[FIELD_W-1], x_value})
                    - $signed({mean_value[FIELD_W-1], mean_value});
    assign diff_abs = diff[FIELD_W] ? (FIELD_W+1)'(-diff) : (FIELD_W+1)'(diff);
    assign mag      = diff_abs[MAG_W-1:0];
    assign bad      = sigma_value[FIELD_W-1] | (sigma_value == '0);
    assign over     = {{HEAD_SHIFT-1{1'b0}}, mag}
                      >= {sigma_value[SIGMA_W-1:0], {HEAD_SHIFT{1'b0}}};

    always_comb
    begin
        in_next.valid  = start;
        in_next.mode   = mode;
        in_next.neg    = diff[FIELD_W];
        in_next.bad    = bad;
        in_next.tail   = over;
        in_next.ld_idx = entry_index;
        in_next.ld_val = entry_value;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_reg <= '0;
        end
        else
        begin
            in_reg <= in_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg   <= mag;
        sigma_reg <= sigma_value[SIGMA_W-1:0];
    end

    // Divider pipeline
    ctrl_t          div_ctrl;
    logic [Q_W-1:0] absz;

    nrm_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .c_in  (in_reg),
        .mag   (mag_reg),
        .sigma (sigma_reg),
        .c_out (div_ctrl),
        .quot  (absz)
    );

    // Position, table read and interpolation
    nrm_interp #(.TABLE_DEPTH(TABLE_DEPTH)) u_interp (
        .clk          (clk),
        .rst_n        (rst_n),
        .c_in         (div_ctrl),
        .absz         (absz),
        .range_limit  (range_reg),
        .inverse_step (step_reg),
        .result_valid (result_valid),
        .result_value (result_value),
        .status       (status)
    );

endmodule

`default_nettype wire

[design/nrm_ram.sv]
// ----------------------------------------------------------------------------
// nrm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module nrm_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write and registered read
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

[design/nrm_div.sv]
// ----------------------------------------------------------------------------
// nrm_div
// Pipelined restoring divider: one quotient bit per stage, Q_W stages.
// ----------------------------------------------------------------------------
`default_nettype none

module nrm_div
    import nrm_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              c_in,
    input  wire logic [MAG_W-1:0]   mag,
    input  wire logic [SIGMA_W-1:0] sigma,
    output ctrl_t                   c_out,
    output logic      [Q_W-1:0]     quot
);

    logic [SIGMA_W-1:0] r_in   [Q_W];
    logic [Q_W-1:0]     w_in   [Q_W];
    logic [SIGMA_W-1:0] s_in   [Q_W];
    ctrl_t              c_src  [Q_W];
    logic [SIGMA_W-1:0] r_reg  [Q_W];
    logic [Q_W-1:0]     w_reg  [Q_W];
    logic [SIGMA_W-1:0] s_reg  [Q_W];
    ctrl_t              c_reg  [Q_W];

    genvar i;
    generate
        for (i = 0; i < Q_W; i++)
        begin : g_stage
            logic [SIGMA_W:0]   trial;
            logic               fits;
            logic [SIGMA_W-1:0] r_next;
            logic [Q_W-1:0]     w_next;

            // Feed the first stage from the item, the rest from the stage before
            if (i == 0)
            begin : g_head
                assign r_in[i]  = SIGMA_W'(mag >> HEAD_SHIFT);
                assign w_in[i]  = {mag[HEAD_SHIFT-1:0], {FRAC_BITS{1'b0}}};
                assign s_in[i]  = sigma;
                assign c_src[i] = c_in;
            end
            else
            begin : g_body
                assign r_in[i]  = r_reg[i-1];
                assign w_in[i]  = w_reg[i-1];
                assign s_in[i]  = s_reg[i-1];
                assign c_src[i] = c_reg[i-1];
            end

            // Shift in the next dividend bit, subtract when the divisor fits
            assign trial  = {r_in[i], w_in[i][Q_W-1]};
            assign fits   = trial >= {1'b0, s_in[i]};
            assign r_next = fits ? SIGMA_W'(trial - {1'b0, s_in[i]}) : SIGMA_W'(trial);
            assign w_next = {w_in[i][Q_W-2:0], fits};

            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    c_reg[i] <= '0;
                end
                else
                begin
                    c_reg[i] <= c_src[i];
                end
            end

            always_ff @(posedge clk)
            begin
                r_reg[i] <= r_next;
                w_reg[i] <= w_next;
                s_reg[i] <= s_in[i];
            end
        end
    endgenerate

    assign c_out = c_reg[Q_W-1];
    assign quot  = w_reg[Q_W-1];

endmodule

`default_nettype wire

[design/nrm_interp.sv]
// ----------------------------------------------------------------------------
// nrm_interp
// Table position, table read and linear interpolation with tail handling.
// ----------------------------------------------------------------------------
`default_nettype none

module nrm_interp
    import nrm_pkg::*;
#(
    parameter int TABLE_DEPTH = 4096
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ctrl_t              c_in,
    input  wire logic [Q_W-1:0]     absz,
    input  wire logic [RANGE_W-1:0] range_limit,
    input  wire logic [STEP_W-1:0]  inverse_step,
    output logic                    result_valid,
    output logic      [ENTRY_W-1:0] result_value,
    output logic      [1:0]         status
);

    localparam int AW = $clog2(TABLE_DEPTH);

    // Stage A: range check and position
    logic [RANGE_W-1:0] lim;
    ctrl_t              a_next;
    ctrl_t              a_reg;
    logic [POS_W-1:0]   pos_reg;

    assign lim = (range_limit > RANGE_CAP) ? RANGE_CAP : range_limit;

    always_comb
    begin
        a_next      = c_in;
        a_next.tail = c_in.tail | (RANGE_W'(absz) > lim);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_reg <= '0;
        end
        else
        begin
            a_reg <= a_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= POS_W'(absz) * POS_W'(inverse_step);
    end

    // Stage B: table read and load writes, in item order
    logic [IDXF_W-1:0]   idx;
    logic [31:0]         idx_p1;
    logic [31:0]         ld_wide;
    logic [AW-1:0]       ra0;
    logic [AW-1:0]       ra1;
    logic [AW-1:0]       wa;
    logic                ld_ok;
    logic                we_pdf;
    logic                we_cdf;
    logic [ENTRY_W-1:0]  pdf0;
    logic [ENTRY_W-1:0]  pdf1;
    logic [ENTRY_W-1:0]  cdf0;
    logic [ENTRY_W-1:0]  cdf1;
    ctrl_t               b_next;
    ctrl_t               b_reg;
    logic [POS_FRAC-1:0] frac_reg;

    assign idx     = pos_reg[POS_W-1:POS_FRAC];
    assign idx_p1  = 32'(idx) + 32'd1;
    assign ld_wide = 32'(a_reg.ld_idx);
    assign ra0     = idx[AW-1:0];
    assign ra1     = idx_p1[AW-1:0];
    assign wa      = ld_wide[AW-1:0];
    assign ld_ok   = ld_wide < 32'(TABLE_DEPTH);
    assign we_pdf  = a_reg.valid & ld_ok & (a_reg.mode == MODE_LOAD_PDF);
    assign we_cdf  = a_reg.valid & ld_ok & (a_reg.mode == MODE_LOAD_CDF);

    always_comb
    begin
        b_next      = a_reg;
        b_next.tail = a_reg.tail | (idx_p1 >= 32'(TABLE_DEPTH));
    end

    nrm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_pdf_lo (
        .clk(clk), .we(we_pdf), .waddr(wa), .wdata(a_reg.ld_val), .raddr(ra0), .rdata(pdf0)
    );
    nrm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_pdf_hi (
        .clk(clk), .we(we_pdf), .waddr(wa), .wdata(a_reg.ld_val), .raddr(ra1), .rdata(pdf1)
    );
    nrm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_cdf_lo (
        .clk(clk), .we(we_cdf), .waddr(wa), .wdata(a_reg.ld_val), .raddr(ra0), .rdata(cdf0)
    );
    nrm_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_cdf_hi (
        .clk(clk), .we(we_cdf), .waddr(wa), .wdata(a_reg.ld_val), .raddr(ra1), .rdata(cdf1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_reg <= '0;
        end
        else
        begin
            b_reg <= b_next;
        end
    end

    always_ff @(posedge clk)
    begin
        frac_reg <= pos_reg[POS_FRAC-1:0];
    end

    // Stage C: slope times fraction
    logic                      is_cdf;
    logic [ENTRY_W-1:0]        t0;
    logic [ENTRY_W-1:0]        t1;
    logic signed [ENTRY_W:0]   slope;
    logic signed [POS_FRAC:0]  frac_s;
    ctrl_t                     c_reg;
    logic [ENTRY_W-1:0]        t0_reg;
    logic signed [PROD_W-1:0]  prod_reg;

    assign is_cdf = b_reg.mode[0];
    assign t0     = is_cdf ? cdf0 : pdf0;
    assign t1     = is_cdf ? cdf1 : pdf1;
    assign slope  = $signed({1'b0, t1}) - $signed({1'b0, t0});
    assign frac_s = $signed({1'b0, frac_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_reg <= '0;
        end
        else
        begin
            c_reg <= b_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        t0_reg   <= t0;
        prod_reg <= PROD_W'(slope) * PROD_W'(frac_s);
    end

    // Stage D: round, saturate, fold and pick the status
    logic signed [ACC_W-1:0] acc;
    logic [ACC_W-POS_FRAC-1:0] v_raw;
    logic [ENTRY_W-1:0]      v_sat;
    logic                    valid_next;
    logic [ENTRY_W-1:0]      value_next;
    logic [1:0]              status_next;
    logic                    valid_reg;
    logic [ENTRY_W-1:0]      value_reg;
    logic [1:0]              status_reg;

    assign acc   = $signed({{(ACC_W-ENTRY_W-POS_FRAC){1'b0}}, t0_reg, {POS_FRAC{1'b0}}})
                 + ACC_W'(prod_reg)
                 + $signed(ACC_W'(1) << (POS_FRAC - 1));
    assign v_raw = acc[ACC_W-1:POS_FRAC];
    assign v_sat = (v_raw > (ACC_W-POS_FRAC)'(PROB_ONE)) ? PROB_ONE : v_raw[ENTRY_W-1:0];

    always_comb
    begin
        valid_next  = c_reg.valid;
        value_next  = '0;
        status_next = STAT_OK;
        if (!c_reg.mode[1])
        begin
            status_next = STAT_LOAD_ACK;
        end
        else if (c_reg.bad)
        begin
            status_next = STAT_BAD_SIG;
        end
        else if (c_reg.tail)
        begin
            status_next = STAT_SAT;
            value_next  = (c_reg.mode[0] && !c_reg.neg) ? PROB_ONE : '0;
        end
        else if (c_reg.mode[0] && c_reg.neg)
        begin
            value_next = PROB_ONE - v_sat;
        end
        else
        begin
            value_next = v_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg  <= value_next;
        status_reg <= status_next;
    end

    assign result_valid = valid_reg;
    assign result_value = value_reg;
    assign status       = status_reg;

endmodule

`default_nettype wire

[tb/sv/normal_pdf_cdf_lut_interp_checker.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// normal_pdf_cdf_lut_interp_checker
// Watches the item, configuration and result ports of the normal table
// block, keeps its own copy of both tables and both registers, predicts the
// result of every item taken and compares it field by field, in order.
// A query that interpolates between entries never loaded is checked on its
// status only.
// ----------------------------------------------------------------------------

module normal_pdf_cdf_lut_interp_checker
    import nrm_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic               busy,
    input  logic [1:0]         mode,
    input  logic signed [23:0] x_value,
    input  logic signed [23:0] mean_value,
    input  logic signed [23:0] sigma_value,
    input  logic [11:0]        entry_index,
    input  logic [16:0]        entry_value,
    input  logic               result_valid,
    input  logic [16:0]        result_value,
    input  logic [1:0]         status,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [23:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_count
);

    typedef struct packed {
        logic [16:0] value;
        logic [1:0]  stat;
        logic        skip;
    } prob_result_t;

    localparam int DEPTH = 4096;

    logic [16:0]  pdf_tab [DEPTH];
    logic [16:0]  cdf_tab [DEPTH];
    logic [21:0]  range_reg;
    logic [23:0]  step_reg;
    prob_result_t expected_q [$];

    // Blend two neighboring entries and clip at one
    function automatic logic [16:0] blend(logic [16:0] lo, logic [16:0] hi,
                                          longint unsigned frac);
        longint unsigned one;
        longint unsigned acc;
        one = 64'd1 << POS_FRAC;
        acc = (longint'(lo) * (one - frac) + longint'(hi) * frac + (one >> 1)) >> POS_FRAC;
        return (acc > PROB_ONE) ? PROB_ONE : acc[16:0];
    endfunction

    // Work out one item's result; loads update the table copies
    function automatic prob_result_t predict_prob(logic [1:0] md, logic signed [23:0] xv,
                                                  logic signed [23:0] mv,
                                                  logic signed [23:0] sv,
                                                  logic [11:0] li, logic [16:0] lv);
        prob_result_t    r;
        longint          diff;
        longint unsigned mag, absz, lim, pos, idx, frac;
        logic            neg, tail;
        logic [16:0]     v;
        r = '0;
        if (md == MODE_LOAD_PDF || md == MODE_LOAD_CDF) begin
            if (md == MODE_LOAD_PDF) pdf_tab[li] = lv;
            else cdf_tab[li] = lv;
            r.stat = STAT_LOAD_ACK;
        end else if (sv <= 0) begin
            r.stat = STAT_BAD_SIG;
        end else begin
            diff = longint'(xv) - longint'(mv);
            neg  = diff < 0;
            mag  = neg ? -diff : diff;
            absz = (mag << FRAC_BITS) / longint'(sv);
            lim  = (range_reg > RANGE_CAP) ? RANGE_CAP : range_reg;
            tail = absz > lim;
            idx  = 0;
            frac = 0;
            if (!tail) begin
                pos  = absz * step_reg;
                idx  = pos >> POS_FRAC;
                frac = pos & ((64'd1 << POS_FRAC) - 1);
                if (idx + 1 >= DEPTH) tail = 1'b1;
            end
            if (tail) begin
                r.stat  = STAT_SAT;
                r.value = (md == MODE_CDF && !neg) ? PROB_ONE : '0;
            end else if (md == MODE_CDF) begin
                r.skip  = $isunknown({cdf_tab[idx], cdf_tab[idx + 1]});
                v = blend(cdf_tab[idx], cdf_tab[idx + 1], frac);
                r.value = neg ? PROB_ONE - v : v;
            end else begin
                r.skip  = $isunknown({pdf_tab[idx], pdf_tab[idx + 1]});
                r.value = blend(pdf_tab[idx], pdf_tab[idx + 1], frac);
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(string what, int got, int want);
        $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // Compare results, take configuration writes, predict accepted items
    always @(posedge clk or negedge rst_n) begin
        prob_result_t want;
        if (!rst_n) begin
            range_reg     = RANGE_RESET;
            step_reg      = STEP_RESET;
            fail_count    = 0;
            pending_count = 0;
            expected_q.delete();
        end else begin
            if (result_valid) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected result", 1, 0);
                end else begin
                    want = expected_q.pop_front();
                    if (!want.skip && result_value !== want.value)
                        report_mismatch("result_value", result_value, want.value);
                    if (status !== want.stat)
                        report_mismatch("status", status, want.stat);
                end
            end
            if (cfg_we) begin
                if (cfg_index == CFG_RANGE) range_reg = cfg_data[21:0];
                else step_reg = cfg_data;
            end
            if (start && !busy)
                expected_q.push_back(predict_prob(mode, x_value, mean_value, sigma_value,
                                                  entry_index, entry_value));
            pending_count = expected_q.size();
        end
    end

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Drives loads and queries into the normal table block through several
// register settings and sender idle rates; a checker beside the block
// predicts and compares every result.
// ----------------------------------------------------------------------------

module testbench;
    import nrm_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int FILL_ENTRIES   = 128;

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [1:0]         mode;
    logic signed [23:0] x_value;
    logic signed [23:0] mean_value;
    logic signed [23:0] sigma_value;
    logic [11:0]        entry_index;
    logic [16:0]        entry_value;
    logic               result_valid;
    logic [16:0]        result_value;
    logic [1:0]         status;
    logic               cfg_we;
    logic               cfg_index;
    logic [23:0]        cfg_data;
    int                 fail_count;
    int                 pending_count;
    int                 idle_pct;
    int                 quiet_cycles;

    normal_pdf_cdf_lut_interp DUT (.*);

    normal_pdf_cdf_lut_interp_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // End the run when nothing transfers for too long
    always @(posedge clk)
    begin
        if (!rst_n || (start && !busy) || result_valid || cfg_we)
            quiet_cycles <= 0;
        else if (quiet_cycles + 1 >= WATCHDOG_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Hold an item on the ports until its transfer, idling at random first
    task automatic send_item(logic [1:0] md, logic signed [23:0] xv,
                             logic signed [23:0] mv, logic signed [23:0] sv,
                             logic [11:0] li, logic [16:0] lv);
        logic taken;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        mode        <= md;
        x_value     <= xv;
        mean_value  <= mv;
        sigma_value <= sv;
        entry_index <= li;
        entry_value <= lv;
        do
        begin
            @(negedge clk);
            taken = !busy;
            @(posedge clk);
        end while (!taken);
    endtask

    // Drop start and wait until every result is back and the pipe is empty
    task automatic drain_all();
        start <= 1'b0;
        @(posedge clk);
        while (pending_count != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic idx, logic [23:0] data);
        drain_all();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_query(logic [1:0] md, longint xv, longint mv, longint sv);
        send_item(md, xv[23:0], mv[23:0], sv[23:0], 12'($urandom), 17'($urandom));
    endtask

    // Mostly well-formed queries around the mean, some loads, some noise
    task automatic random_items(int count);
        longint sv, mv, zq, xv;
        int     pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                send_item($urandom_range(0, 1) ? MODE_LOAD_CDF : MODE_LOAD_PDF,
                          24'($urandom), 24'($urandom), 24'($urandom),
                          12'($urandom), $urandom_range(0, 9) == 0 ? 17'($urandom)
                                         : 17'($urandom_range(0, 65536)));
            else if (pick < 32)
                send_item($urandom_range(0, 1) ? MODE_CDF : MODE_PDF,
                          24'($urandom), 24'($urandom), 24'($urandom),
                          12'($urandom), 17'($urandom));
            else
            begin
                sv = $urandom_range(1 << 10, 1 << 19);
                mv = longint'($urandom_range(0, 1 << 22)) - (1 << 21);
                zq = longint'($urandom_range(0, 8 << 16)) - (4 << 16);
                xv = mv + ((zq * sv) >>> FRAC_BITS);
                if (xv > 8388607) xv = 8388607;
                if (xv < -8388608) xv = -8388608;
                send_query($urandom_range(0, 1) ? MODE_CDF : MODE_PDF, xv, mv, sv);
            end
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        start       = 1'b0;
        mode        = MODE_LOAD_PDF;
        x_value     = '0;
        mean_value  = '0;
        sigma_value = '0;
        entry_index = '0;
        entry_value = '0;
        cfg_we      = 1'b0;
        cfg_index   = CFG_RANGE;
        cfg_data    = '0;
        idle_pct    = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Fill the low entries of both tables, where most queries land
        for (int i = 0; i < FILL_ENTRIES; i++)
        begin
            send_item(MODE_LOAD_PDF, '0, '0, '0, 12'(i), 17'($urandom_range(0, 65536)));
            send_item(MODE_LOAD_CDF, '0, '0, '0, 12'(i), 17'($urandom_range(0, 65536)));
        end

        // Directed: extremes, bad sigma, tails, oversized entries
        send_item(MODE_LOAD_PDF, '0, '0, '0, 12'd4095, 17'h1FFFF);
        send_item(MODE_LOAD_CDF, '0, '0, '0, 12'd0, 17'd65536);
        send_item(MODE_LOAD_PDF, '0, '0, '0, 12'd1, 17'h1FFFF);
        send_query(MODE_PDF, 0, 0, 1 << 16);
        send_query(MODE_CDF, 0, 0, 1 << 16);
        send_query(MODE_PDF, 1 << 10, 0, 1 << 16);
        send_query(MODE_CDF, -(1 << 16), 0, 1 << 16);
        send_query(MODE_PDF, 0, 0, 0);
        send_query(MODE_CDF, 0, 0, -8388608);
        send_query(MODE_PDF, 5, 0, -1);
        send_query(MODE_CDF, 8388607, -8388608, 1);
        send_query(MODE_CDF, -8388608, 8388607, 1);
        send_query(MODE_PDF, 8388607, -8388608, 8388607);
        send_query(MODE_PDF, 6 << 16, 0, 1 << 16);
        send_query(MODE_CDF, (6 << 16) + 1, 0, 1 << 16);
        send_query(MODE_CDF, -((6 << 16) + 1), 0, 1 << 16);
        send_query(MODE_PDF, -8388608, -8388608, 8388607);

        // Phase: widest range, reset step, no idling
        write_reg(CFG_RANGE, 24'd2555904);
        send_query(MODE_CDF, 39 << 16, 0, 1 << 16);
        send_query(MODE_PDF, 40 << 16, 0, 1 << 16);
        random_items(140);

        // Phase: range above the cap, largest step, sender mostly idle
        write_reg(CFG_RANGE, 24'hFFFFFF);
        write_reg(CFG_STEP, 24'hFFFFFF);
        idle_pct = 69;
        send_query(MODE_CDF, 1, 0, 1 << 16);
        send_query(MODE_PDF, 1 << 16, 0, 1 << 16);
        random_items(70);

        // Phase: zero step reads entry zero, range zero saturates all but z = 0
        write_reg(CFG_STEP, 24'd0);
        idle_pct = 19;
        random_items(40);
        write_reg(CFG_RANGE, 24'd0);
        send_query(MODE_PDF, 0, 0, 1 << 16);
        send_query(MODE_CDF, 1, 0, 1 << 16);
        random_items(40);

        // Phase: unit step, then default step with no idling, then default range
        write_reg(CFG_RANGE, 24'd393216);
        write_reg(CFG_STEP, 24'd1);
        idle_pct = 69;
        random_items(80);
        write_reg(CFG_STEP, 24'd25600);
        write_reg(CFG_RANGE, 24'h3FFFFF);
        idle_pct = 0;
        random_items(100);
        write_reg(CFG_RANGE, 24'd393216);
        idle_pct = 19;
        random_items(90);

        drain_all();
        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
